### design/b64_pkg.sv
// Package with the item types, status codes and the alphabet lookup of the base64 decoder.
package b64_pkg;

   // Status carried on the final result item of a message.
   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_BAD_LENGTH  = 2'd1,
      STATUS_BAD_CHAR    = 2'd2,
      STATUS_BAD_PADDING = 2'd3
   } status_type;

   localparam logic [7:0] PAD_CHAR = 8'h3d;

   // One input item: a character and its last-character mark.
   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_payload_type;

   // One result item.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
      status_type status;
   } rsp_payload_type;

   // One queue entry: up to three result items produced by a single input item.
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      last_index;
      logic            bytes_valid;
      logic            end_flag;
      status_type      status;
   } q_entry_type;

   // Maps a character to its 6-bit value; bit 6 set means not in the alphabet.
   function automatic logic [6:0] sextet_of(input logic [7:0] c, input logic url);
      logic [7:0] diff;
      logic [6:0] result;
      diff   = 8'd0;
      result = 7'h40;
      if (c >= 8'h41 && c <= 8'h5a) begin
         diff   = c - 8'h41;
         result = {1'b0, diff[5:0]};
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         diff   = c - 8'h61 + 8'd26;
         result = {1'b0, diff[5:0]};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         diff   = c - 8'h30 + 8'd52;
         result = {1'b0, diff[5:0]};
      end else if (c == 8'h2b || (url && c == 8'h2d)) begin
         result = 7'd62;
      end else if (c == 8'h2f || (url && c == 8'h5f)) begin
         result = 7'd63;
      end
      return result;
   endfunction

endpackage

### design/base64_stream_decoder.sv
// Top level of the streaming base64 decoder.
// The decoder takes one character per cycle on the req_ channel and gives decoded bytes
// on the rsp_ channel, one result item per cycle while rsp_ready is high. A group of four
// characters yields three bytes, issued one after another from a short queue of entries, so
// the output rate of one item per cycle keeps pace with input at one character per cycle. The
// final character of a message yields the closing item with end_of_message set and the
// status; on a bad status it is the only item of that step and its byte is not valid. The front
// end updates its state in the cycle a character is accepted, and the first result of that
// character passes through a queue slot and then the output register before it appears on
// rsp_. Input is held off only while the queue of QUEUE_DEPTH entries is full. url_mode is
// written through the csr_ port, which is always ready; write it only while no message is in
// flight. There is no clearing pass after reset.
module base64_stream_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  b64_pkg::req_payload_type req_item,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output b64_pkg::rsp_payload_type rsp_item
);
   import b64_pkg::*;

   logic        q_push, q_pop, q_empty, q_full;
   q_entry_type push_entry, head_entry;

   // Character intake and classification.
   b64_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (push_entry)
   );

   // Entry queue between intake and output.
   b64_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .empty      (q_empty),
      .full       (q_full)
   );

   // Result item issue.
   b64_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

endmodule

### design/b64_front.sv
// Front end: accepts characters, tracks group and padding state and pushes result entries.
module b64_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  b64_pkg::req_payload_type req_item,
   input  logic                     q_full,
   output logic                     q_push,
   output b64_pkg::q_entry_type     q_entry
);
   import b64_pkg::*;

   logic        url_mode_ff, url_mode_in;
   logic [1:0]  sextet_count_ff, sextet_count_in;
   logic [17:0] held_ff, held_in;
   logic [1:0]  length_ff, length_in;
   logic        in_padding_ff, in_padding_in;
   logic [2:0]  pad_count_ff, pad_count_in;
   status_type  error_ff, error_in;

   logic        accept;
   logic [6:0]  lookup;
   logic [5:0]  v;
   logic [2:0]  pad_inc;
   logic        group_done;
   logic [2:0][7:0] group_bytes;
   status_type  final_status;
   q_entry_type entry;

   assign csr_ready = 1'b1;
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign lookup    = sextet_of(req_item.char_code, url_mode_ff);
   assign v         = lookup[5:0];
   assign pad_inc   = (pad_count_ff < 3'd7) ? pad_count_ff + 3'd1 : pad_count_ff;

   // Bytes of a full group: three held values and the one just arrived.
   assign group_bytes[0] = {held_ff[17:12], held_ff[11:10]};
   assign group_bytes[1] = {held_ff[9:6], held_ff[5:2]};
   assign group_bytes[2] = {held_ff[1:0], v};

   // Next message state and the entry that this character produces.
   always_comb begin
      sextet_count_in = sextet_count_ff;
      held_in         = held_ff;
      in_padding_in   = in_padding_ff;
      pad_count_in    = pad_count_ff;
      error_in        = error_ff;
      group_done      = 1'b0;
      final_status    = STATUS_OK;
      entry           = '0;
      if (error_ff == STATUS_OK) begin
         if (!in_padding_ff) begin
            if (req_item.char_code == PAD_CHAR) begin
               if (sextet_count_ff < 2'd2) begin
                  error_in = STATUS_BAD_PADDING;
               end else begin
                  in_padding_in = 1'b1;
                  pad_count_in  = 3'd1;
               end
            end else if (lookup[6]) begin
               error_in = STATUS_BAD_CHAR;
            end else if (sextet_count_ff == 2'd3) begin
               group_done      = 1'b1;
               held_in         = '0;
               sextet_count_in = 2'd0;
            end else begin
               held_in         = {held_ff[11:0], v};
               sextet_count_in = sextet_count_ff + 2'd1;
            end
         end else begin
            if (req_item.char_code != PAD_CHAR) begin
               error_in = STATUS_BAD_PADDING;
            end else begin
               pad_count_in = pad_inc;
               if ({2'b00, sextet_count_ff} + {1'b0, pad_inc} > 4'd4) begin
                  error_in = STATUS_BAD_PADDING;
               end
            end
         end
      end
      length_in = length_ff + 2'd1;

      if (group_done) begin
         entry.bytes       = group_bytes;
         entry.last_index  = 2'd2;
         entry.bytes_valid = 1'b1;
      end

      // The final character closes the message and reports its status.
      if (req_item.last_char) begin
         if ((!url_mode_ff && length_in != 2'd0) || (url_mode_ff && length_in == 2'd1)) begin
            final_status = STATUS_BAD_LENGTH;
         end else begin
            final_status = error_in;
         end
         entry.end_flag = 1'b1;
         entry.status   = final_status;
         if (final_status != STATUS_OK) begin
            entry.bytes       = '0;
            entry.last_index  = 2'd0;
            entry.bytes_valid = 1'b0;
         end else if (!group_done) begin
            if (sextet_count_in == 2'd2) begin
               entry.bytes[0]    = {held_in[11:6], held_in[5:4]};
               entry.last_index  = 2'd0;
               entry.bytes_valid = 1'b1;
            end else if (sextet_count_in == 2'd3) begin
               entry.bytes[0]    = {held_in[17:12], held_in[11:10]};
               entry.bytes[1]    = {held_in[9:6], held_in[5:2]};
               entry.last_index  = 2'd1;
               entry.bytes_valid = 1'b1;
            end
         end
         sextet_count_in = 2'd0;
         held_in         = '0;
         length_in       = 2'd0;
         in_padding_in   = 1'b0;
         pad_count_in    = 3'd0;
         error_in        = STATUS_OK;
      end
   end

   assign q_push  = accept && (group_done || req_item.last_char);
   assign q_entry = entry;

   assign url_mode_in = (csr_valid && csr_ready) ? csr_data : url_mode_ff;

   // State registers; message state moves only on an accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         url_mode_ff     <= 1'b0;
         sextet_count_ff <= 2'd0;
         held_ff         <= '0;
         length_ff       <= 2'd0;
         in_padding_ff   <= 1'b0;
         pad_count_ff    <= 3'd0;
         error_ff        <= STATUS_OK;
      end else begin
         url_mode_ff <= url_mode_in;
         if (accept) begin
            sextet_count_ff <= sextet_count_in;
            held_ff         <= held_in;
            length_ff       <= length_in;
            in_padding_ff   <= in_padding_in;
            pad_count_ff    <= pad_count_in;
            error_ff        <= error_in;
         end
      end
   end

endmodule

### design/b64_queue.sv
// Short queue of result entries between the front end and the output stage.
module b64_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  b64_pkg::q_entry_type push_entry,
   input  logic                 pop,
   output b64_pkg::q_entry_type head_entry,
   output logic                 empty,
   output logic                 full
);
   import b64_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

   q_entry_type      slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head_entry = slots_ff[rd_ptr_ff];

   // Pointer and fill count updates with explicit wrap.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; no reset needed for payload.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("entry pushed into a full queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count beyond depth");
`endif

endmodule

### design/b64_back.sv
// Output stage: spreads each queue entry over one to three result items.
module b64_back (
   input  logic                     clock,
   input  logic                     reset,
   input  b64_pkg::q_entry_type     head_entry,
   input  logic                     q_empty,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output b64_pkg::rsp_payload_type rsp_item
);
   import b64_pkg::*;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_item_ff, rsp_item_in;
   logic [1:0]      index_ff, index_in;
   logic            load;
   logic            final_of_entry;

   assign load           = !q_empty && (!rsp_valid_ff || rsp_ready);
   assign final_of_entry = (index_ff == head_entry.last_index);
   assign q_pop          = load && final_of_entry;

   // Select the byte at the current index and build the result item.
   always_comb begin
      rsp_item_in = rsp_item_ff;
      index_in    = index_ff;
      if (load) begin
         case (index_ff)
            2'd0:    rsp_item_in.data_byte = head_entry.bytes[0];
            2'd1:    rsp_item_in.data_byte = head_entry.bytes[1];
            2'd2:    rsp_item_in.data_byte = head_entry.bytes[2];
            default: rsp_item_in.data_byte = 8'd0;
         endcase
         rsp_item_in.byte_valid     = head_entry.bytes_valid;
         rsp_item_in.end_of_message = head_entry.end_flag && final_of_entry;
         rsp_item_in.status         = (head_entry.end_flag && final_of_entry) ?
                                      head_entry.status : STATUS_OK;
         index_in = final_of_entry ? 2'd0 : index_ff + 2'd1;
      end
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         index_ff     <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         index_ff     <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.status != STATUS_OK) |-> rsp_item_ff.end_of_message)
      else $error("error status on an item that does not end the message");
   a_empty_item_is_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_item_ff.byte_valid) |->
      (rsp_item_ff.end_of_message && rsp_item_ff.data_byte == 8'd0))
      else $error("item without a byte that is not a clean final item");
   a_index_in_entry: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> (index_ff <= head_entry.last_index))
      else $error("item index ran past the end of its entry");
`endif

endmodule
